// ===== design/breakpoint_table_lerp_core_defines.svh =====
// Assertion helpers shared by the breakpoint table core
`ifndef BREAKPOINT_TABLE_LERP_CORE_DEFINES_SVH
`define BREAKPOINT_TABLE_LERP_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define BTL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset
`define BTL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/btl_pkg.sv =====
`default_nettype none

package btl_pkg;

   // Table geometry and fixed point format
   localparam int TABLE_DEPTH   = 8;
   localparam int FRACTION_BITS = 16;
   localparam int IDX_W         = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;

   // Quotient magnitude: |num| < 2^16, shifted by the fraction bits
   localparam int QUO_W  = 16 + FRACTION_BITS;
   localparam int CNT_W  = $clog2(QUO_W);
   // Multiplier takes the quotient in two halves
   localparam int MUL_H  = (QUO_W + 1) / 2;
   localparam int PROD_W = 21 + MUL_H + 1;
   localparam int ACC_W  = 22 + QUO_W;
   localparam int OFF_SHIFT = FRACTION_BITS - 8;

   // Opcodes
   localparam logic OP_QUERY = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // Result status codes
   localparam logic [1:0] ST_BASE    = 2'd0;
   localparam logic [1:0] ST_EXACT   = 2'd1;
   localparam logic [1:0] ST_INTERP  = 2'd2;
   localparam logic [1:0] ST_BADSPAN = 2'd3;

   // Result source select
   localparam logic [1:0] RES_BASE   = 2'd0;
   localparam logic [1:0] RES_CUR    = 2'd1;
   localparam logic [1:0] RES_INTERP = 2'd2;

   // Multiplier sequence phases
   localparam logic [2:0] MUL_H_LO  = 3'd0;
   localparam logic [2:0] MUL_H_HI  = 3'd1;
   localparam logic [2:0] MUL_O_LO  = 3'd2;
   localparam logic [2:0] MUL_O_HI  = 3'd3;
   localparam logic [2:0] MUL_O_ACC = 3'd4;

   typedef struct packed {
      logic               opcode;
      logic [2:0]         entry_index;
      logic signed [15:0] key;
      logic signed [19:0] entry_height;
      logic signed [15:0] entry_offset;
   } req_type;

   typedef struct packed {
      logic signed [19:0] height_out;
      logic signed [23:0] offset_out;
      logic [1:0]         status;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic       table_write;
      logic       query_start;
      logic       scan_adv;
      logic       div_start;
      logic       div_step;
      logic       mul_en;
      logic [2:0] mul_phase;
      logic       rnd;
      logic       load_out;
      logic [1:0] res_sel;
      logic [1:0] res_status;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic key_zero;
      logic cur_term;
      logic cur_eq;
      logic cur_gt;
      logic span_bad;
      logic scan_last;
   } status_type;

endpackage

`default_nettype wire

// ===== design/breakpoint_table_lerp_core.sv =====
// Breakpoint table with piecewise linear interpolation.
// Request channel (req_valid/req_ready/req_payload): a write beat stores one
// breakpoint (key, height, offset) at entry_index and returns nothing; a query
// beat returns exactly one beat on the response channel (rsp_valid/rsp_ready/
// rsp_payload) with height, offset and status.
// Sequence: a write leaves the core ready, so the next beat is taken in the
// next cycle. A query with key zero skips the scan; otherwise the scan visits
// one table entry per cycle, and an interpolating query then runs the
// bit-serial divider, the shared multiplier and a rounding step. One query is
// in flight at a time.
// The result sits in an output register; while it waits, new beats (writes,
// or the next query) are still accepted, and a finished query holds until the
// register is free. A stalled receiver therefore blocks at most one query.
// Reset sets every key to the -1 terminator, heights and offsets to zero,
// and clears the sequencer and response valid.
`default_nettype none

`include "breakpoint_table_lerp_core_defines.svh"

module breakpoint_table_lerp_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire btl_pkg::req_type  req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output btl_pkg::rsp_type       rsp_payload
);

   btl_pkg::cmd_type    cmd;
   btl_pkg::status_type status;

   btl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_payload.opcode),
      .req_ready  (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .status     (status),
      .cmd        (cmd)
   );

   btl_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

   // Checks
   `BTL_ASSERT_NOW(a_no_overwrite, clock, reset, cmd.load_out, !rsp_valid || rsp_ready, "result overwritten before it was taken")
   `BTL_ASSERT_NOW(a_div_good_span, clock, reset, cmd.div_start, !status.span_bad && status.cur_gt, "divider started on a bad span")
   `BTL_ASSERT_NOW(a_query_start, clock, reset, cmd.query_start, req_valid && req_ready && req_payload.opcode == btl_pkg::OP_QUERY, "query started without an accepted query beat")
   `BTL_ASSERT_NEXT(a_query_busy, clock, reset, req_valid && req_ready && req_payload.opcode == btl_pkg::OP_QUERY, !req_ready, "ready stayed high after a query")

endmodule

`default_nettype wire

// ===== design/btl_datapath.sv =====
`default_nettype none

module btl_datapath (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire btl_pkg::req_type   req_payload,
   input  wire btl_pkg::cmd_type   cmd,
   output btl_pkg::status_type     status,
   output btl_pkg::rsp_type        rsp_payload
);

   localparam int DEPTH = btl_pkg::TABLE_DEPTH;
   localparam int IW    = btl_pkg::IDX_W;
   localparam int QW    = btl_pkg::QUO_W;
   localparam int MH    = btl_pkg::MUL_H;
   localparam int PW    = btl_pkg::PROD_W;
   localparam int AW    = btl_pkg::ACC_W;
   localparam int FB    = btl_pkg::FRACTION_BITS;
   localparam int OS    = btl_pkg::OFF_SHIFT;
   localparam logic signed [AW-1:0] HALF_H = AW'(1) <<< (FB - 1);
   localparam logic signed [AW-1:0] HALF_O = (AW'(1) <<< OS) >>> 1;

   function automatic logic signed [19:0] sat20(input logic signed [AW-1:0] v);
      logic ovf;
      ovf = (v[AW-1:19] != {(AW-19){v[AW-1]}});
      if (!ovf) return v[19:0];
      return v[AW-1] ? {1'b1, 19'd0} : {1'b0, {19{1'b1}}};
   endfunction

   function automatic logic signed [23:0] sat24(input logic signed [AW-1:0] v);
      logic ovf;
      ovf = (v[AW-1:23] != {(AW-23){v[AW-1]}});
      if (!ovf) return v[23:0];
      return v[AW-1] ? {1'b1, 23'd0} : {1'b0, {23{1'b1}}};
   endfunction

   // Breakpoint table in flops
   logic signed [15:0] key_ff [DEPTH];
   logic signed [19:0] hgt_ff [DEPTH];
   logic signed [15:0] off_ff [DEPTH];

   // Query context
   logic signed [15:0] qkey_ff;
   logic [IW-1:0]      idx_ff;
   logic signed [15:0] prev_k_ff;
   logic signed [19:0] prev_h_ff;
   logic signed [15:0] prev_o_ff;

   // Divider and multiplier state
   logic [15:0]          rem_ff, rem_in;
   logic [QW-1:0]        quo_ff, quo_in;
   logic [15:0]          den_ff;
   logic                 neg_ff;
   logic signed [20:0]   dh_ff;
   logic signed [16:0]   doff_ff;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic signed [AW-1:0] acc_h_ff, acc_o_ff;
   logic signed [AW-1:0] rnd_h_ff, rnd_o_ff;
   btl_pkg::rsp_type     rsp_ff, rsp_in;

   logic signed [15:0] cur_k;
   logic signed [19:0] cur_h;
   logic signed [15:0] cur_o;
   logic signed [16:0] den;
   logic signed [16:0] num;
   logic [16:0]        num_mag;
   logic [16:0]        shifted;
   logic [17:0]        trial;
   logic signed [20:0] mul_a;
   logic [MH-1:0]      mul_b;
   logic signed [AW-1:0] sum_h, sum_o;

   assign cur_k = key_ff[idx_ff];
   assign cur_h = hgt_ff[idx_ff];
   assign cur_o = off_ff[idx_ff];

   assign den     = 17'(cur_k) - 17'(prev_k_ff);
   assign num     = 17'(qkey_ff) - 17'(prev_k_ff);
   assign num_mag = num[16] ? 17'(-num) : 17'(num);

   // Scan decisions
   always_comb begin
      status.key_zero  = (req_payload.key == 16'sd0);
      status.cur_term  = (cur_k == -16'sd1);
      status.cur_eq    = (cur_k == qkey_ff);
      status.cur_gt    = (cur_k > qkey_ff);
      status.span_bad  = den[16] || (den == 17'sd0);
      status.scan_last = (idx_ff == IW'(DEPTH - 1));
   end

   // Table writes; writes beyond the table are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            key_ff[i] <= -16'sd1;
            hgt_ff[i] <= '0;
            off_ff[i] <= '0;
         end
      end else if (cmd.table_write && (32'(req_payload.entry_index) < DEPTH)) begin
         key_ff[IW'(req_payload.entry_index)] <= req_payload.key;
         hgt_ff[IW'(req_payload.entry_index)] <= req_payload.entry_height;
         off_ff[IW'(req_payload.entry_index)] <= req_payload.entry_offset;
      end
   end

   // Scan position and lower breakpoint
   always_ff @(posedge clock) begin
      if (cmd.query_start) begin
         qkey_ff   <= req_payload.key;
         idx_ff    <= IW'(1);
         prev_k_ff <= key_ff[0];
         prev_h_ff <= hgt_ff[0];
         prev_o_ff <= off_ff[0];
      end else if (cmd.scan_adv) begin
         idx_ff    <= idx_ff + IW'(1);
         prev_k_ff <= cur_k;
         prev_h_ff <= cur_h;
         prev_o_ff <= cur_o;
      end
   end

   // Restoring divider, one quotient bit a cycle
   always_comb begin
      shifted = {rem_ff, quo_ff[QW-1]};
      trial   = {1'b0, shifted} - {2'b00, den_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (cmd.div_start) begin
         rem_in = '0;
         quo_in = {num_mag[15:0], {FB{1'b0}}};
      end else if (cmd.div_step) begin
         if (!trial[17]) begin
            rem_in = trial[15:0];
            quo_in = {quo_ff[QW-2:0], 1'b1};
         end else begin
            rem_in = shifted[15:0];
            quo_in = {quo_ff[QW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (cmd.div_start) begin
         den_ff  <= den[15:0];
         neg_ff  <= num[16];
         dh_ff   <= 21'(cur_h) - 21'(prev_h_ff);
         doff_ff <= 17'(cur_o) - 17'(prev_o_ff);
      end
   end

   // Shared multiplier over the quotient halves
   always_comb begin
      if (cmd.mul_phase == btl_pkg::MUL_H_LO || cmd.mul_phase == btl_pkg::MUL_H_HI) begin
         mul_a = dh_ff;
      end else begin
         mul_a = 21'(doff_ff);
      end
      if (cmd.mul_phase == btl_pkg::MUL_H_LO || cmd.mul_phase == btl_pkg::MUL_O_LO) begin
         mul_b = quo_ff[MH-1:0];
      end else begin
         mul_b = MH'(quo_ff[QW-1:MH]);
      end
      prod_in = PW'(mul_a) * PW'($signed({1'b0, mul_b}));
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
         case (cmd.mul_phase)
            btl_pkg::MUL_H_HI:  acc_h_ff <= AW'(prod_ff);
            btl_pkg::MUL_O_LO:  acc_h_ff <= acc_h_ff + (AW'(prod_ff) <<< MH);
            btl_pkg::MUL_O_HI:  acc_o_ff <= AW'(prod_ff);
            btl_pkg::MUL_O_ACC: acc_o_ff <= acc_o_ff + (AW'(prod_ff) <<< MH);
            default: ;
         endcase
      end
   end

   // Sign of the quotient and the rounding half in one add
   always_ff @(posedge clock) begin
      if (cmd.rnd) begin
         rnd_h_ff <= neg_ff ? (HALF_H - acc_h_ff) : (acc_h_ff + HALF_H);
         rnd_o_ff <= neg_ff ? (HALF_O - acc_o_ff) : (acc_o_ff + HALF_O);
      end
   end

   assign sum_h = (rnd_h_ff >>> FB) + AW'(prev_h_ff);
   assign sum_o = (rnd_o_ff >>> OS) + (AW'(prev_o_ff) <<< 8);

   // Output register
   always_comb begin
      rsp_in = rsp_ff;
      case (cmd.res_sel)
         btl_pkg::RES_BASE: begin
            rsp_in.height_out = hgt_ff[0];
            rsp_in.offset_out = {off_ff[0], 8'd0};
         end
         btl_pkg::RES_CUR: begin
            rsp_in.height_out = cur_h;
            rsp_in.offset_out = {cur_o, 8'd0};
         end
         btl_pkg::RES_INTERP: begin
            rsp_in.height_out = sat20(sum_h);
            rsp_in.offset_out = sat24(sum_o);
         end
         default: begin
            rsp_in.height_out = hgt_ff[0];
            rsp_in.offset_out = {off_ff[0], 8'd0};
         end
      endcase
      rsp_in.status = cmd.res_status;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

// ===== design/btl_ctrl.sv =====
`default_nettype none

module btl_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_opcode,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire btl_pkg::status_type  status,
   output btl_pkg::cmd_type          cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_DIV  = 3'd2;
   localparam logic [2:0] S_MUL  = 3'd3;
   localparam logic [2:0] S_RND  = 3'd4;
   localparam logic [2:0] S_EMIT = 3'd5;

   localparam int CW = btl_pkg::CNT_W;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [1:0]    sel_ff, sel_in;
   logic [1:0]    st_ff, st_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          accept;
   logic          slot_free;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      sel_in       = sel_ff;
      st_in        = st_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.res_sel    = sel_ff;
      cmd.res_status = st_ff;
      cmd.mul_phase  = cnt_ff[2:0];

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_opcode == btl_pkg::OP_WRITE) begin
                  cmd.table_write = 1'b1;
               end else begin
                  cmd.query_start = 1'b1;
                  if (status.key_zero) begin
                     sel_in   = btl_pkg::RES_BASE;
                     st_in    = btl_pkg::ST_BASE;
                     state_in = S_EMIT;
                  end else begin
                     state_in = S_SCAN;
                  end
               end
            end
         end
         S_SCAN: begin
            if (status.cur_term) begin
               sel_in   = btl_pkg::RES_BASE;
               st_in    = btl_pkg::ST_BASE;
               state_in = S_EMIT;
            end else if (status.cur_eq) begin
               sel_in   = btl_pkg::RES_CUR;
               st_in    = btl_pkg::ST_EXACT;
               state_in = S_EMIT;
            end else if (status.cur_gt) begin
               if (status.span_bad) begin
                  sel_in   = btl_pkg::RES_CUR;
                  st_in    = btl_pkg::ST_BADSPAN;
                  state_in = S_EMIT;
               end else begin
                  cmd.div_start = 1'b1;
                  sel_in   = btl_pkg::RES_INTERP;
                  st_in    = btl_pkg::ST_INTERP;
                  cnt_in   = '0;
                  state_in = S_DIV;
               end
            end else if (status.scan_last) begin
               sel_in   = btl_pkg::RES_BASE;
               st_in    = btl_pkg::ST_BASE;
               state_in = S_EMIT;
            end else begin
               cmd.scan_adv = 1'b1;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == CW'(btl_pkg::QUO_W - 1)) begin
               cnt_in   = '0;
               state_in = S_MUL;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         S_MUL: begin
            cmd.mul_en = 1'b1;
            if (cnt_ff[2:0] == btl_pkg::MUL_O_ACC) begin
               cnt_in   = '0;
               state_in = S_RND;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         S_RND: begin
            cmd.rnd  = 1'b1;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            // wait for the output register to free up
            if (slot_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sel_ff <= sel_in;
      st_ff  <= st_in;
   end

endmodule

`default_nettype wire
